@@ rtl/fsd_pkg.sv @@
package fsd_pkg;

    localparam int ALT_WIDTH_DEF = 24;

    localparam int ALT_THR_W   = 23;
    localparam int ACCEL_W     = 16;
    localparam int TIMEOUT_W   = 32;
    localparam int ELAPSED_W   = 16;
    localparam int STAGE_W     = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [STAGE_W-1:0] {
        STAGE_PAD     = 3'd0,
        STAGE_ASCENT  = 3'd1,
        STAGE_APOGEE  = 3'd2,
        STAGE_DESCENT = 3'd3,
        STAGE_LANDING = 3'd4
    } stage_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALT_THR   = 2'd0,
        REG_ACCEL_THR = 2'd1,
        REG_TIMEOUT   = 2'd2
    } cfg_reg_t;

    localparam logic [ALT_THR_W-1:0]        ALT_THR_RESET   = 23'd500;
    localparam logic signed [ACCEL_W-1:0]   ACCEL_THR_RESET = -16'sd2000;
    localparam logic [TIMEOUT_W-1:0]        TIMEOUT_RESET   = 32'd600000;

    typedef struct packed {
        logic [ALT_THR_W-1:0]      alt_thr;
        logic signed [ACCEL_W-1:0] accel_thr;
        logic [TIMEOUT_W-1:0]      timeout;
    } cfg_t;

endpackage

@@ rtl/flight_stage_detector_unit.sv @@
// channel   ports                                                   direction
// s_        s_valid s_ready s_elapsed_ms s_altitude_cm s_accel_vertical  in
// m_        m_valid m_ready m_stage m_peak_altitude_cm m_timed_out       out
// cfg_      cfg_we cfg_index cfg_data (write only, no wait)              in
//
// one request per cycle sustained while m_ready stays high; a result passes through the
// input register, then the result register with the stage logic between
// reset: stage launchpad, peak 0, timer cleared and disarmed, registers at defaults
// a stalled result holds the result register; the input register still takes one
// more request, after which s_ready drops until the result is taken
module flight_stage_detector_unit #(
    parameter int ALT_WIDTH = fsd_pkg::ALT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fsd_pkg::ELAPSED_W-1:0]      s_elapsed_ms,
    input  logic signed [ALT_WIDTH-1:0]        s_altitude_cm,
    input  logic signed [fsd_pkg::ACCEL_W-1:0] s_accel_vertical,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fsd_pkg::STAGE_W-1:0]        m_stage,
    output logic signed [ALT_WIDTH-1:0]        m_peak_altitude_cm,
    output logic                               m_timed_out,
    input  logic                               cfg_we,
    input  logic [fsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fsd_pkg::*;

    cfg_t cfg;

    logic                        in_valid_reg;
    logic [ELAPSED_W-1:0]        elapsed_reg;
    logic signed [ALT_WIDTH-1:0] alt_reg;
    logic signed [ACCEL_W-1:0]   accel_reg;

    logic                        out_valid_reg;
    stage_t                      stage_out_reg;
    logic signed [ALT_WIDTH-1:0] peak_out_reg;
    logic                        timed_out_reg;

    logic                        fire;
    stage_t                      stage_next;
    logic signed [ALT_WIDTH-1:0] peak_next;
    logic                        timed_out_next;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    fsd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsd_core #(
        .ALT_WIDTH (ALT_WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .fire           (fire),
        .elapsed_ms     (elapsed_reg),
        .altitude_cm    (alt_reg),
        .accel_vertical (accel_reg),
        .stage_next     (stage_next),
        .peak_next      (peak_next),
        .timed_out      (timed_out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            elapsed_reg <= s_elapsed_ms;
            alt_reg     <= s_altitude_cm;
            accel_reg   <= s_accel_vertical;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            stage_out_reg <= stage_next;
            peak_out_reg  <= peak_next;
            timed_out_reg <= timed_out_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_stage            = stage_out_reg;
    assign m_peak_altitude_cm = peak_out_reg;
    assign m_timed_out        = timed_out_reg;

    a_timeout_means_landing: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && timed_out_reg |-> stage_out_reg == STAGE_LANDING)
        else $error("timeout reported outside landing");

    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed request produced no result");

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted request lost");

endmodule

@@ rtl/fsd_cfg.sv @@
module fsd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [fsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output fsd_pkg::cfg_t                  cfg
);
    import fsd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ALT_THR:   cfg_next.alt_thr   = cfg_data[ALT_THR_W-1:0];
                REG_ACCEL_THR: cfg_next.accel_thr = signed'(cfg_data[ACCEL_W-1:0]);
                REG_TIMEOUT:   cfg_next.timeout   = cfg_data[TIMEOUT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alt_thr   <= ALT_THR_RESET;
            cfg_reg.accel_thr <= ACCEL_THR_RESET;
            cfg_reg.timeout   <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/fsd_core.sv @@
module fsd_core #(
    parameter int ALT_WIDTH = fsd_pkg::ALT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fsd_pkg::cfg_t                      cfg,
    input  logic                               fire,
    input  logic [fsd_pkg::ELAPSED_W-1:0]      elapsed_ms,
    input  logic signed [ALT_WIDTH-1:0]        altitude_cm,
    input  logic signed [fsd_pkg::ACCEL_W-1:0] accel_vertical,
    output fsd_pkg::stage_t                    stage_next,
    output logic signed [ALT_WIDTH-1:0]        peak_next,
    output logic                               timed_out
);
    import fsd_pkg::*;

    // wide enough for altitude, the unsigned threshold and peak minus threshold
    localparam int CMP_W = ((ALT_WIDTH > ALT_THR_W) ? ALT_WIDTH : ALT_THR_W) + 2;

    stage_t                      stage_reg;
    logic signed [ALT_WIDTH-1:0] peak_reg;
    logic [TIMEOUT_W-1:0]        since_reg;
    logic                        armed_reg;
    logic [TIMEOUT_W-1:0]        since_next;
    logic                        armed_next;

    logic [TIMEOUT_W:0]      sum;
    logic [TIMEOUT_W-1:0]    since_sat;
    logic signed [CMP_W-1:0] alt_x;
    logic signed [CMP_W-1:0] thr_x;
    logic signed [CMP_W-1:0] peak_x;
    stage_t                  stage_mid;

    assign sum       = {1'b0, since_reg} + {{(TIMEOUT_W+1-ELAPSED_W){1'b0}}, elapsed_ms};
    assign since_sat = sum[TIMEOUT_W] ? {TIMEOUT_W{1'b1}} : sum[TIMEOUT_W-1:0];
    assign alt_x     = CMP_W'(altitude_cm);
    assign thr_x     = signed'({{(CMP_W-ALT_THR_W){1'b0}}, cfg.alt_thr});

    always_comb begin
        since_next = since_reg;
        armed_next = armed_reg;
        timed_out  = 1'b0;
        stage_mid  = stage_reg;
        peak_next  = peak_reg;
        // timeout check runs before the stage step
        if (armed_reg) begin
            since_next = since_sat;
            if (since_sat > cfg.timeout) begin
                stage_mid = STAGE_LANDING;
                timed_out = 1'b1;
            end
        end
        stage_next = stage_mid;
        peak_x     = CMP_W'(peak_reg);
        unique case (stage_mid)
            STAGE_PAD: begin
                if (alt_x > thr_x || accel_vertical < cfg.accel_thr) begin
                    stage_next = STAGE_ASCENT;
                end
            end
            STAGE_ASCENT: begin
                if (altitude_cm > peak_reg) begin
                    peak_next = altitude_cm;
                end
                peak_x = CMP_W'(peak_next);
                if (alt_x < peak_x - thr_x) begin
                    stage_next = STAGE_APOGEE;
                end
            end
            STAGE_APOGEE: begin
                stage_next = STAGE_DESCENT;
                since_next = '0;
                armed_next = 1'b1;
            end
            default: begin
                stage_next = stage_mid;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= STAGE_PAD;
            peak_reg  <= '0;
            since_reg <= '0;
            armed_reg <= 1'b0;
        end else if (fire) begin
            stage_reg <= stage_next;
            peak_reg  <= peak_next;
            since_reg <= since_next;
            armed_reg <= armed_next;
        end
    end

    // timer only runs once apogee has passed
    a_armed_after_apogee: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> (stage_reg == STAGE_DESCENT || stage_reg == STAGE_LANDING))
        else $error("timer armed before apogee");

    a_landing_final: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && stage_reg == STAGE_LANDING |=> stage_reg == STAGE_LANDING)
        else $error("left landing stage");

    a_peak_only_in_ascent: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && stage_reg == STAGE_ASCENT) |=> $stable(peak_reg))
        else $error("peak changed outside ascent");

endmodule
